// File: hw/rtl/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types, constants and opcode codes for the MIPS subset execute block.
// ----------------------------------------------------------------------------
package mse_pkg;

	localparam int unsigned MemWords = 1024;
	localparam int unsigned MemAw    = $clog2(MemWords);
	localparam int unsigned RegCount = 32;
	localparam int unsigned RegAw    = $clog2(RegCount);

	// opcode field
	localparam logic [5:0] OP_SPECIAL = 6'h00;
	localparam logic [5:0] OP_ADDI    = 6'h08;
	localparam logic [5:0] OP_BEQ     = 6'h04;
	localparam logic [5:0] OP_BNE     = 6'h05;
	localparam logic [5:0] OP_BGTZ    = 6'h07;
	localparam logic [5:0] OP_BLEZ    = 6'h06;
	localparam logic [5:0] OP_LUI     = 6'h0F;
	localparam logic [5:0] OP_LW      = 6'h23;
	localparam logic [5:0] OP_SW      = 6'h2B;

	// funct field
	localparam logic [5:0] FN_ADD  = 6'h20;
	localparam logic [5:0] FN_SUB  = 6'h22;
	localparam logic [5:0] FN_AND  = 6'h24;
	localparam logic [5:0] FN_OR   = 6'h25;
	localparam logic [5:0] FN_XOR  = 6'h26;
	localparam logic [5:0] FN_SLT  = 6'h2A;
	localparam logic [5:0] FN_SLL  = 6'h00;
	localparam logic [5:0] FN_SRL  = 6'h02;
	localparam logic [5:0] FN_MULT = 6'h18;
	localparam logic [5:0] FN_DIV  = 6'h1A;
	localparam logic [5:0] FN_MFHI = 6'h10;
	localparam logic [5:0] FN_MFLO = 6'h12;
	localparam logic [5:0] FN_JR   = 6'h08;

	typedef struct packed {
		logic        reg_write_en;
		logic [4:0]  reg_write_index;
		logic [31:0] reg_write_value;
		logic [31:0] pc_after;
		logic [31:0] hi_value;
		logic [31:0] lo_value;
		logic        mem_write_en;
		logic [31:0] mem_byte_address;
		logic [31:0] mem_write_data;
		logic        illegal;
	} result_t;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture instruction, start register reads
		logic decode;     // operands valid, evaluate and issue
		logic mul_step;   // one shift-add step
		logic div_step;   // one restoring step
		logic finish;     // commit result
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_mul;
		logic is_div;
		logic is_lw;
		logic iter_last;
	} dp_status_t;

endpackage

// File: hw/rtl/mse_stream_if.sv
// ----------------------------------------------------------------------------
// mse_stream_if
// Valid/ready channels, each carrying one payload: an instruction word or a result record.
// ----------------------------------------------------------------------------
interface mse_instr_if;
	logic        valid;
	logic        ready;
	logic [31:0] instruction;
	modport source (output valid, output instruction, input ready);
	modport sink   (input valid, input instruction, output ready);
endinterface

interface mse_result_if;
	logic                  valid;
	logic                  ready;
	mse_pkg::result_t      result;
	modport source (output valid, output result, input ready);
	modport sink   (input valid, input result, output ready);
endinterface

// File: hw/rtl/mse_ram.sv
// ----------------------------------------------------------------------------
// mse_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mse_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: hw/rtl/mse_datapath.sv
// ----------------------------------------------------------------------------
// mse_datapath
// Register file, HI/LO/PC, data memory, ALU and iterative multiply/divide.
// ----------------------------------------------------------------------------
module mse_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         instruction,
	input  mse_pkg::dp_cmd_t    cmd,
	output mse_pkg::dp_status_t status,
	output mse_pkg::result_t    result
);
	logic [31:0] ins_q;

	// register file: two read copies, valid bits stand for the zero reset
	logic [mse_pkg::RegCount-1:0] rvalid_q;
	logic [31:0] rs_raw, rt_raw, rs_v, rt_v;
	logic [mse_pkg::RegAw-1:0] rs_idx_q, rt_idx_q;
	logic                      rf_we;
	logic [mse_pkg::RegAw-1:0] rf_waddr;
	logic [31:0]               rf_wdata;

	logic [5:0]  opc, fn;
	logic [4:0]  rs, rt, rd, sa;
	logic [31:0] imm;
	logic [31:0] addr_calc;

	// data memory, zeroed by a clearing pass after reset
	logic [mse_pkg::MemAw-1:0] clr_q;
	logic                      clr_busy_q;
	logic                      dm_we;
	logic [mse_pkg::MemAw-1:0] dm_waddr, dm_raddr;
	logic [31:0]               dm_wdata, dm_rdata;

	// operands latched at decode
	logic [31:0] a_q, b_q, addr_q;
	logic [31:0] hi_q, lo_q, pc_q;
	mse_pkg::result_t res_q;

	// multiply / divide iterative state
	logic [63:0] acc_q;
	logic [31:0] mc_q;
	logic [5:0]  cnt_q;
	logic        neg_q, rneg_q;
	logic [31:0] ma, mb;
	logic [32:0] dtrial;
	logic        status_mul_q, status_div_q, status_lw_q;
	logic [63:0] mul_p;

	mse_pkg::result_t r;
	logic [31:0] hi_n, lo_n, pc_n;
	logic [31:0] fin_val;

	assign opc = ins_q[31:26];
	assign rs  = ins_q[25:21];
	assign rt  = ins_q[20:16];
	assign rd  = ins_q[15:11];
	assign sa  = ins_q[10:6];
	assign fn  = ins_q[5:0];
	assign imm = {{16{ins_q[15]}}, ins_q[15:0]};

	mse_ram #(.Width(32), .Depth(mse_pkg::RegCount)) u_rf_a (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr(instruction[25:21]), .rdata(rs_raw)
	);
	mse_ram #(.Width(32), .Depth(mse_pkg::RegCount)) u_rf_b (
		.clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
		.raddr(instruction[20:16]), .rdata(rt_raw)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ins_q    <= instruction;
			rs_idx_q <= instruction[25:21];
			rt_idx_q <= instruction[20:16];
		end
	end

	assign rs_v = rvalid_q[rs_idx_q] ? rs_raw : 32'd0;
	assign rt_v = rvalid_q[rt_idx_q] ? rt_raw : 32'd0;

	mse_ram #(.Width(32), .Depth(mse_pkg::MemWords)) u_dmem (
		.clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
		.raddr(dm_raddr), .rdata(dm_rdata)
	);

	assign ma = rs_v[31] ? (~rs_v + 32'd1) : rs_v;
	assign mb = rt_v[31] ? (~rt_v + 32'd1) : rt_v;

	assign dtrial = {acc_q[63:31]} - {1'b0, mc_q};

	assign addr_calc = rs_v + imm;

	assign status.is_mul    = (opc == mse_pkg::OP_SPECIAL) && (fn == mse_pkg::FN_MULT);
	assign status.is_div    = (opc == mse_pkg::OP_SPECIAL) && (fn == mse_pkg::FN_DIV)
	                          && (rt_v != 32'd0);
	assign status.is_lw     = (opc == mse_pkg::OP_LW);
	assign status.iter_last = (cnt_q == 6'd31);
	// hold the load address on the read port so the word stays valid until output
	assign dm_raddr = cmd.decode ? addr_calc[mse_pkg::MemAw+1:2] : addr_q[mse_pkg::MemAw+1:2];

	// decode-cycle result (everything but mult/div/lw data)
	always_comb begin
		r = '0;
		hi_n = hi_q;
		lo_n = lo_q;
		pc_n = pc_q;
		if (opc == mse_pkg::OP_SPECIAL) begin
			case (fn)
				mse_pkg::FN_ADD: begin r.reg_write_en = 1'b1; r.reg_write_index = rd;
					r.reg_write_value = rs_v + rt_v; end
				mse_pkg::FN_SUB: begin r.reg_write_en = 1'b1; r.reg_write_index = rd;
					r.reg_write_value = rs_v - rt_v; end
				mse_pkg::FN_AND: begin r.reg_write_en = 1'b1; r.reg_write_index = rd;
					r.reg_write_value = rs_v & rt_v; end
				mse_pkg::FN_OR: begin r.reg_write_en = 1'b1; r.reg_write_index = rd;
					r.reg_write_value = rs_v | rt_v; end
				mse_pkg::FN_XOR: begin r.reg_write_en = 1'b1; r.reg_write_index = rd;
					r.reg_write_value = rs_v ^ rt_v; end
				mse_pkg::FN_SLT: begin r.reg_write_en = 1'b1; r.reg_write_index = rd;
					r.reg_write_value = {31'd0, $signed(rs_v) < $signed(rt_v)}; end
				mse_pkg::FN_SLL: begin r.reg_write_en = 1'b1; r.reg_write_index = rd;
					r.reg_write_value = rt_v << sa; end
				mse_pkg::FN_SRL: begin r.reg_write_en = 1'b1; r.reg_write_index = rd;
					if (rs == 5'd1)
						r.reg_write_value = (rt_v >> sa) | (rt_v << (6'd32 - {1'b0, sa}));
					else
						r.reg_write_value = rt_v >> sa;
				end
				mse_pkg::FN_MULT: begin end
				mse_pkg::FN_DIV: begin
					if (rt_v == 32'd0) begin
						hi_n = rs_v;
						lo_n = 32'hFFFF_FFFF;
					end
				end
				mse_pkg::FN_MFHI: begin r.reg_write_en = 1'b1; r.reg_write_index = rd;
					r.reg_write_value = hi_q; end
				mse_pkg::FN_MFLO: begin r.reg_write_en = 1'b1; r.reg_write_index = rd;
					r.reg_write_value = lo_q; end
				mse_pkg::FN_JR: pc_n = rs_v;
				default: r.illegal = 1'b1;
			endcase
		end else begin
			case (opc)
				mse_pkg::OP_ADDI: begin r.reg_write_en = 1'b1; r.reg_write_index = rt;
					r.reg_write_value = rs_v + imm; end
				mse_pkg::OP_BEQ: if (rs_v == rt_v) pc_n = pc_q + {imm[29:0], 2'b00};
				mse_pkg::OP_BNE: if (rs_v != rt_v) pc_n = pc_q + {imm[29:0], 2'b00};
				mse_pkg::OP_BGTZ: if (!rs_v[31] && rs_v != 32'd0)
					pc_n = pc_q + {imm[29:0], 2'b00};
				mse_pkg::OP_BLEZ: if (rs_v[31] || rs_v == 32'd0)
					pc_n = pc_q + {imm[29:0], 2'b00};
				mse_pkg::OP_LUI: begin r.reg_write_en = 1'b1; r.reg_write_index = rt;
					r.reg_write_value = {ins_q[15:0], 16'd0}; end
				mse_pkg::OP_LW: begin r.reg_write_en = 1'b1; r.reg_write_index = rt;
					r.mem_byte_address = addr_calc; end
				mse_pkg::OP_SW: begin r.mem_write_en = 1'b1;
					r.mem_byte_address = addr_calc; r.mem_write_data = rt_v; end
				default: r.illegal = 1'b1;
			endcase
		end
		if (r.reg_write_index == 5'd0) begin
			r.reg_write_en = 1'b0;
			r.reg_write_value = 32'd0;
		end
	end

	// the clearing pass owns the write port until it is done
	assign dm_we    = clr_busy_q || (cmd.decode && r.mem_write_en);
	assign dm_waddr = clr_busy_q ? clr_q : addr_calc[mse_pkg::MemAw+1:2];
	assign dm_wdata = clr_busy_q ? 32'd0 : rt_v;

	// clearing pass after reset: zero every data word and register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == mse_pkg::MemAw'(mse_pkg::MemWords - 1)) clr_busy_q <= 1'b0;
		end
	end

	// commit: register file, HI/LO/PC
	assign fin_val  = status_lw_q ? dm_rdata : res_q.reg_write_value;
	assign rf_we    = (cmd.finish && res_q.reg_write_en) || clr_busy_q;
	assign rf_waddr = clr_busy_q ? clr_q[mse_pkg::RegAw-1:0] : res_q.reg_write_index;
	assign rf_wdata = clr_busy_q ? 32'd0 : fin_val;

	assign mul_p = neg_q ? (~acc_q + 64'd1) : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q     <= '0;
			lo_q     <= '0;
			pc_q     <= '0;
			rvalid_q <= '0;
		end else begin
			if (cmd.decode) begin
				hi_q <= hi_n;
				lo_q <= lo_n;
				pc_q <= pc_n;
			end
			if (cmd.finish && res_q.reg_write_en)
				rvalid_q[res_q.reg_write_index] <= 1'b1;
			if (cmd.finish && status_mul_q) begin
				hi_q <= mul_p[63:32];
				lo_q <= mul_p[31:0];
			end
			if (cmd.finish && status_div_q) begin
				hi_q <= rneg_q ? (~acc_q[63:32] + 32'd1) : acc_q[63:32];
				lo_q <= neg_q  ? (~acc_q[31:0] + 32'd1) : acc_q[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			status_mul_q <= 1'b0;
			status_div_q <= 1'b0;
			status_lw_q  <= 1'b0;
		end else begin
			if (cmd.decode) begin
				cnt_q        <= '0;
				status_mul_q <= status.is_mul;
				status_div_q <= status.is_div;
				status_lw_q  <= status.is_lw;
			end else if (cmd.mul_step || cmd.div_step) begin
				cnt_q <= cnt_q + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			res_q  <= r;
			a_q    <= ma;
			b_q    <= mb;
			addr_q <= addr_calc;
			mc_q   <= mb;
			neg_q  <= rs_v[31] ^ rt_v[31];
			rneg_q <= rs_v[31];
			acc_q  <= status.is_mul ? 64'd0 : {32'd0, ma};
		end else if (cmd.mul_step) begin
			// shift-add, MSB first over multiplier a_q
			acc_q <= {acc_q[62:0], 1'b0} + (a_q[~cnt_q[4:0]] ? {32'd0, b_q} : 64'd0);
		end else if (cmd.div_step) begin
			if (!dtrial[32])
				acc_q <= {dtrial[31:0], acc_q[30:0], 1'b1};
			else
				acc_q <= {acc_q[62:0], 1'b0};
		end
	end

	// assemble final result
	always_comb begin
		result = res_q;
		result.pc_after = pc_q;
		result.hi_value = hi_q;
		result.lo_value = lo_q;
		if (status_lw_q && res_q.reg_write_en)
			result.reg_write_value = dm_rdata;
	end
endmodule

// File: hw/rtl/mse_ctrl.sv
// ----------------------------------------------------------------------------
// mse_ctrl
// Sequencer: accept, read, execute, iterate, commit, hand out the result.
// ----------------------------------------------------------------------------
module mse_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  logic                busy_clear,
	input  mse_pkg::dp_status_t status,
	output mse_pkg::dp_cmd_t    cmd
);
	typedef enum logic [2:0] {S_IDLE, S_DEC, S_MUL, S_DIV, S_FIN, S_OUT} state_t;
	state_t state_q;

	assign in_ready  = (state_q == S_IDLE) && !busy_clear;
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd          = '0;
		cmd.load     = in_valid && in_ready;
		cmd.decode   = (state_q == S_DEC);
		cmd.mul_step = (state_q == S_MUL);
		cmd.div_step = (state_q == S_DIV);
		cmd.finish   = (state_q == S_FIN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid && in_ready) state_q <= S_DEC;
				S_DEC: begin
					if (status.is_mul)      state_q <= S_MUL;
					else if (status.is_div) state_q <= S_DIV;
					else                    state_q <= S_FIN;
				end
				S_MUL: if (status.iter_last) state_q <= S_FIN;
				S_DIV: if (status.iter_last) state_q <= S_FIN;
				S_FIN: state_q <= S_OUT;
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.decode, cmd.mul_step, cmd.div_step, cmd.finish}))
		else $error("two phases at once");
	a_dec_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.decode) else $error("decode did not follow load");
	a_out_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid) else $error("result not shown after commit");
endmodule

// File: hw/rtl/mips_subset_execute_top.sv
// Sequence: an instruction that is taken passes through decode, commit and
//   present; mult and nonzero div add shift-add/restoring steps before commit.
// Flow: a new instruction is taken only after the previous result has been
//   accepted, so any wait for ready holds off the next one.
// Reset: arst_n clears PC, HI, LO, register valid bits; a clearing pass then
//   zeroes data memory and register RAM, during which no transaction is taken.
// ----------------------------------------------------------------------------
// mips_subset_execute_top
// Executes one MIPS subset instruction per transaction and reports its effects.
// ----------------------------------------------------------------------------
module mips_subset_execute_top (
	input  logic                 clk,
	input  logic                 arst_n,
	mse_instr_if.sink            instr,
	mse_result_if.source         res
);
	mse_pkg::dp_cmd_t    cmd;
	mse_pkg::dp_status_t status;
	logic                clr_busy;
	logic                u_dp_busy;
	logic [mse_pkg::MemAw:0] boot_q;

	// hold off transactions while the memory clearing pass runs
	assign clr_busy = u_dp_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			boot_q <= '0;
		end else if (!boot_q[mse_pkg::MemAw]) begin
			boot_q <= boot_q + 1'b1;
		end
	end
	assign u_dp_busy = !boot_q[mse_pkg::MemAw];

	mse_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(instr.valid), .in_ready(instr.ready),
		.out_valid(res.valid), .out_ready(res.ready),
		.busy_clear(clr_busy), .status(status), .cmd(cmd)
	);

	mse_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .instruction(instr.instruction),
		.cmd(cmd), .status(status), .result(res.result)
	);
endmodule

// File: dv/mse_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mse_checker
// Watches the instruction and result channels, predicts each result from its
// own copy of the architectural state, and compares field by field.
// ----------------------------------------------------------------------------
module mse_checker
	import mse_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	mse_instr_if.sink   instr,
	mse_result_if.sink  res,
	output int          errors,
	output int          pending
);

	logic [31:0] gpr [RegCount];
	logic [31:0] mem [MemWords];
	logic [31:0] hi_q, lo_q, pc_q;
	result_t     expected_results [$];

	function automatic logic [31:0] sext(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic result_t execute_instr(input logic [31:0] ins);
		result_t     r;
		logic [5:0]  opc, fn;
		logic [4:0]  rs, rt, rd, sa;
		logic [31:0] vs, vt, imm, widx_val, q, rm, ma, mb;
		logic [63:0] prod;
		logic        wen;
		logic [4:0]  widx;
		opc = ins[31:26]; fn = ins[5:0];
		rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11]; sa = ins[10:6];
		vs = gpr[rs]; vt = gpr[rt]; imm = sext(ins[15:0]);
		r = '0; wen = 0; widx = 0; widx_val = 0;
		if (opc == OP_SPECIAL) begin
			case (fn)
				FN_ADD: begin wen = 1; widx = rd; widx_val = vs + vt; end
				FN_SUB: begin wen = 1; widx = rd; widx_val = vs - vt; end
				FN_AND: begin wen = 1; widx = rd; widx_val = vs & vt; end
				FN_OR: begin wen = 1; widx = rd; widx_val = vs | vt; end
				FN_XOR: begin wen = 1; widx = rd; widx_val = vs ^ vt; end
				FN_SLT: begin
					wen = 1; widx = rd;
					widx_val = {31'd0, $signed(vs) < $signed(vt)};
				end
				FN_SLL: begin wen = 1; widx = rd; widx_val = vt << sa; end
				FN_SRL: begin
					wen = 1; widx = rd;
					if (rs == 5'd1 && sa != 0) widx_val = (vt >> sa) | (vt << (6'd32 - sa));
					else widx_val = vt >> sa;
				end
				FN_MULT: begin
					prod = $signed({{32{vs[31]}}, vs}) * $signed({{32{vt[31]}}, vt});
					hi_q = prod[63:32]; lo_q = prod[31:0];
				end
				FN_DIV: begin
					if (vt == 0) begin
						lo_q = 32'hFFFF_FFFF; hi_q = vs;
					end else begin
						ma = vs[31] ? -vs : vs;
						mb = vt[31] ? -vt : vt;
						q = ma / mb; rm = ma % mb;
						lo_q = (vs[31] != vt[31]) ? -q : q;
						hi_q = vs[31] ? -rm : rm;
					end
				end
				FN_MFHI: begin wen = 1; widx = rd; widx_val = hi_q; end
				FN_MFLO: begin wen = 1; widx = rd; widx_val = lo_q; end
				FN_JR: pc_q = vs;
				default: r.illegal = 1;
			endcase
		end else begin
			case (opc)
				OP_ADDI: begin wen = 1; widx = rt; widx_val = vs + imm; end
				OP_BEQ: if (vs == vt) pc_q = pc_q + (imm << 2);
				OP_BNE: if (vs != vt) pc_q = pc_q + (imm << 2);
				OP_BGTZ: if ($signed(vs) > 0) pc_q = pc_q + (imm << 2);
				OP_BLEZ: if ($signed(vs) <= 0) pc_q = pc_q + (imm << 2);
				OP_LUI: begin wen = 1; widx = rt; widx_val = {ins[15:0], 16'd0}; end
				OP_LW: begin
					r.mem_byte_address = vs + imm;
					wen = 1; widx = rt;
					widx_val = mem[r.mem_byte_address[MemAw+1:2]];
				end
				OP_SW: begin
					r.mem_byte_address = vs + imm;
					r.mem_write_en = 1; r.mem_write_data = vt;
					mem[r.mem_byte_address[MemAw+1:2]] = vt;
				end
				default: r.illegal = 1;
			endcase
		end
		if (wen && widx != 0) begin
			gpr[widx] = widx_val;
			r.reg_write_en = 1; r.reg_write_index = widx; r.reg_write_value = widx_val;
		end
		r.pc_after = pc_q; r.hi_value = hi_q; r.lo_value = lo_q;
		return r;
	endfunction

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		result_t e;
		if (!arst_n) begin
			for (int i = 0; i < RegCount; i++) gpr[i] = '0;
			for (int i = 0; i < MemWords; i++) mem[i] = '0;
			hi_q = '0; lo_q = '0; pc_q = '0;
			errors <= 0;
			expected_results.delete();
		end else begin
			// compare the result first: its expectation was queued on an earlier edge
			if (res.valid && res.ready) begin
				if (expected_results.size() == 0) begin
					$error("result transaction with nothing expected");
					errors <= errors + 1;
				end else begin
					e = expected_results.pop_front();
					if (res.result !== e) begin
						errors <= errors + 1;
						if (res.result.reg_write_en !== e.reg_write_en)
							$error("reg_write_en exp %0h got %0h",
								e.reg_write_en, res.result.reg_write_en);
						if (res.result.reg_write_index !== e.reg_write_index)
							$error("reg_write_index exp %0h got %0h",
								e.reg_write_index, res.result.reg_write_index);
						if (res.result.reg_write_value !== e.reg_write_value)
							$error("reg_write_value exp %0h got %0h",
								e.reg_write_value, res.result.reg_write_value);
						if (res.result.pc_after !== e.pc_after)
							$error("pc_after exp %0h got %0h",
								e.pc_after, res.result.pc_after);
						if (res.result.hi_value !== e.hi_value)
							$error("hi_value exp %0h got %0h",
								e.hi_value, res.result.hi_value);
						if (res.result.lo_value !== e.lo_value)
							$error("lo_value exp %0h got %0h",
								e.lo_value, res.result.lo_value);
						if (res.result.mem_write_en !== e.mem_write_en)
							$error("mem_write_en exp %0h got %0h",
								e.mem_write_en, res.result.mem_write_en);
						if (res.result.mem_byte_address !== e.mem_byte_address)
							$error("mem_byte_address exp %0h got %0h",
								e.mem_byte_address, res.result.mem_byte_address);
						if (res.result.mem_write_data !== e.mem_write_data)
							$error("mem_write_data exp %0h got %0h",
								e.mem_write_data, res.result.mem_write_data);
						if (res.result.illegal !== e.illegal)
							$error("illegal exp %0h got %0h",
								e.illegal, res.result.illegal);
					end
				end
			end
			if (instr.valid && instr.ready)
				expected_results.push_back(execute_instr(instr.instruction));
		end
	end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives MIPS subset instructions into the execute block with random gaps and
// result back-pressure; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
	import mse_pkg::*;

	logic clk;
	logic arst_n;
	int   errors;
	int   pending;
	int   idle_cycles;
	bit   quiet;          // no idling on either side while set

	mse_instr_if  instr ();
	mse_result_if res ();

	mips_subset_execute_top u_dut (.clk(clk), .arst_n(arst_n), .instr(instr), .res(res));
	mse_checker u_chk (.clk(clk), .arst_n(arst_n), .instr(instr), .res(res),
		.errors(errors), .pending(pending));

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		instr.valid = 0;
		instr.instruction = '0;
		res.ready = 0;
		quiet = 0;
		arst_n = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
	end

	// Randomly stall the result side about 11 percent of the time, unless quiet.
	always @(posedge clk) begin
		res.ready <= quiet || ($urandom_range(99) >= 11);
	end

	// Watchdog: count edges with no transaction on either channel. The reset
	// clearing pass and a divide sit well inside its limit.
	always @(posedge clk) begin
		if ((instr.valid && instr.ready) || (res.valid && res.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("FAIL mips_subset_execute_top");
			$finish;
		end
	end

	function automatic logic [31:0] rtype(input logic [4:0] rs, rt, rd, sa, input logic [5:0] fn);
		return {OP_SPECIAL, rs, rt, rd, sa, fn};
	endfunction

	function automatic logic [31:0] itype(input logic [5:0] op, input logic [4:0] rs, rt,
		input logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	// Hold valid until the transaction is taken; idle beforehand at random.
	// Valid stays high on return; the caller drops it when the burst ends.
	task automatic send(input logic [31:0] ins);
		while (!quiet && $urandom_range(99) < 11) begin
			instr.valid <= 0;
			@(posedge clk);
		end
		instr.valid <= 1;
		instr.instruction <= ins;
		@(posedge clk);
		while (!instr.ready) @(posedge clk);
	endtask

	// Pick a random legal or illegal instruction; mostly legal ops with
	// small register indexes so values flow between instructions.
	function automatic logic [31:0] random_instr();
		logic [5:0]  fns [13];
		logic [5:0]  ops [8];
		logic [4:0]  rs, rt, rd, sa;
		logic [15:0] imm;
		int          pick;
		fns = '{FN_ADD, FN_SUB, FN_AND, FN_OR, FN_XOR, FN_SLT, FN_SLL, FN_SRL,
			FN_MULT, FN_DIV, FN_MFHI, FN_MFLO, FN_JR};
		ops = '{OP_ADDI, OP_BEQ, OP_BNE, OP_BGTZ, OP_BLEZ, OP_LUI, OP_LW, OP_SW};
		rs = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
		rt = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
		rd = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
		sa = 5'($urandom);
		imm = 16'($urandom);
		pick = $urandom_range(99);
		if (pick < 4) return $urandom;
		if (pick < 12) return rtype(5'd1, rt, rd, sa, FN_SRL);   // rotate
		if (pick < 55) return rtype(rs, rt, rd, sa, fns[$urandom_range(12)]);
		return itype(ops[$urandom_range(7)], rs, rt, imm);
	endfunction

	initial begin
		logic [31:0] directed [$];
		directed = '{
			itype(OP_LUI, 5'd0, 5'd1, 16'h8000),          // r1 = 0x80000000
			itype(OP_ADDI, 5'd0, 5'd2, 16'hFFFF),         // r2 = -1
			itype(OP_ADDI, 5'd0, 5'd0, 16'h1234),         // write to register zero dropped
			rtype(5'd1, 5'd2, 5'd3, 5'd0, FN_SUB),        // r3 = 0x80000001, no overflow
			rtype(5'd1, 5'd1, 5'd4, 5'd0, FN_ADD),
			rtype(5'd1, 5'd2, 5'd5, 5'd0, FN_SLT),
			rtype(5'd1, 5'd2, 5'd0, 5'd0, FN_DIV),        // divide overflow
			rtype(5'd1, 5'd0, 5'd0, 5'd0, FN_DIV),        // divide by zero
			rtype(5'd0, 5'd0, 5'd6, 5'd0, FN_MFHI),
			rtype(5'd0, 5'd0, 5'd7, 5'd0, FN_MFLO),
			rtype(5'd2, 5'd2, 5'd0, 5'd0, FN_MULT),
			rtype(5'd0, 5'd2, 5'd8, 5'd31, FN_SLL),
			rtype(5'd0, 5'd2, 5'd9, 5'd31, FN_SRL),
			rtype(5'd1, 5'd1, 5'd10, 5'd0, FN_SRL),       // rotate by zero
			rtype(5'd1, 5'd1, 5'd11, 5'd4, FN_SRL),       // rotate
			rtype(5'd1, 5'd2, 5'd12, 5'd0, FN_XOR),
			itype(OP_SW, 5'd2, 5'd1, 16'h7FFF),           // unaligned address, wraps index
			itype(OP_LW, 5'd2, 5'd13, 16'h7FFF),
			itype(OP_BEQ, 5'd0, 5'd0, 16'h8000),
			itype(OP_BNE, 5'd1, 5'd0, 16'h7FFF),
			itype(OP_BGTZ, 5'd2, 5'd0, 16'h0001),
			itype(OP_BLEZ, 5'd1, 5'd0, 16'hFFFF),
			rtype(5'd1, 5'd0, 5'd0, 5'd0, FN_JR),
			rtype(5'd0, 5'd0, 5'd0, 5'd0, 6'h3F),         // unknown funct
			32'hFFFF_FFFF                                 // unknown opcode
		};
		wait (arst_n === 1'b1);
		@(posedge clk);
		foreach (directed[i]) send(directed[i]);
		instr.valid <= 0;
		// Hold off until the pipeline drains at least once.
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
		for (int n = 0; n < 1300; n++) begin
			quiet <= (n >= 500 && n < 650);
			send(random_instr());
		end
		quiet <= 0;
		instr.valid <= 0;
		@(posedge clk);
		wait (pending == 0);
		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("PASS mips_subset_execute_top");
		end else begin
			$display("FAIL mips_subset_execute_top");
		end
		$finish;
	end

endmodule
